@@ design/uf_pkg.sv @@
package uf_pkg;

    localparam int DEF_NUM_ELEMENTS = 1024;

    // Fixed field widths of the stream words.
    localparam int ELEM_W     = 10;
    localparam int SIZE_OUT_W = 11;
    localparam int ROOT_OUT_W = 10;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    // Operation codes carried in s_tuser.
    localparam logic MODE_UNITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;          // capture a new word, start at the first element
        logic clr_step;      // write one entry of the post-reset clearing pass
        logic sel_b;         // the second element's lookup is in progress
        logic cur_from_elem; // restart the cursor at the selected element
        logic cur_load_b;    // move the cursor to the second element
        logic cur_from_up;   // step the cursor to the parent just read
        logic set_root;      // the cursor is the root of the selected element
        logic cmp_write;     // point the cursor's entry at the selected root
        logic size_rd_b;     // read the second root's size instead of the first
        logic cap_sa;        // hold the first root's size
        logic link;          // merge the sets if needed and load the result
    } uf_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic is_root;  // the parent just read equals the cursor
        logic at_root;  // the cursor has reached the selected root
        logic clr_last; // the clearing pass is at its last entry
    } uf_status_t;

endpackage

@@ design/uf_datapath.sv @@
module uf_datapath #(
    parameter int NUM_ELEMENTS = uf_pkg::DEF_NUM_ELEMENTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  uf_pkg::uf_cmd_t                  cmd,
    output uf_pkg::uf_status_t               status,
    input  logic                             mode,
    input  logic [uf_pkg::ELEM_W-1:0]        first_element,
    input  logic [uf_pkg::ELEM_W-1:0]        second_element,
    output logic                             same_set,
    output logic [uf_pkg::SIZE_OUT_W-1:0]    set_size,
    output logic [uf_pkg::ROOT_OUT_W-1:0]    set_root
);
    import uf_pkg::*;

    localparam int IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int SZ_W  = $clog2(NUM_ELEMENTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMENTS - 1);

    logic [IDX_W-1:0] parent_mem [NUM_ELEMENTS];
    logic [SZ_W-1:0]  size_mem   [NUM_ELEMENTS];

    logic             mode_reg;
    logic [IDX_W-1:0] a_reg, b_reg, cur_reg, ra_reg, rb_reg, clr_cnt_reg;
    logic [SZ_W-1:0]  sa_reg;
    logic [IDX_W-1:0] parent_rdata_reg;
    logic [SZ_W-1:0]  size_rdata_reg;
    logic             same_reg;
    logic [SIZE_OUT_W-1:0] size_out_reg;
    logic [ROOT_OUT_W-1:0] root_out_reg;

    logic [IDX_W-1:0] a_clamped, b_clamped;
    logic [IDX_W-1:0] root_sel, elem_sel, big, small_root, size_raddr;
    logic [SZ_W-1:0]  sum_size, res_size;
    logic             unite;
    logic             pw_en, sw_en;
    logic [IDX_W-1:0] pw_addr, pw_data, sw_addr;
    logic [SZ_W-1:0]  sw_data;

    // Indices past the end of the table fold onto the last entry.
    always_comb begin
        if (32'(first_element) >= 32'(NUM_ELEMENTS)) begin
            a_clamped = LAST_IDX;
        end else begin
            a_clamped = IDX_W'(first_element);
        end
        if (32'(second_element) >= 32'(NUM_ELEMENTS)) begin
            b_clamped = LAST_IDX;
        end else begin
            b_clamped = IDX_W'(second_element);
        end
    end

    assign root_sel   = cmd.sel_b ? rb_reg : ra_reg;
    assign elem_sel   = cmd.sel_b ? b_reg : a_reg;
    assign size_raddr = cmd.size_rd_b ? rb_reg : ra_reg;
    assign unite      = (mode_reg == MODE_UNITE) && (ra_reg != rb_reg);

    // During the link step sa_reg holds the first root's size and the read
    // register the second's. On a tie the first root stays on top.
    assign big        = (sa_reg < size_rdata_reg) ? rb_reg : ra_reg;
    assign small_root = (sa_reg < size_rdata_reg) ? ra_reg : rb_reg;
    assign sum_size   = SZ_W'(sa_reg + size_rdata_reg);
    assign res_size   = unite ? sum_size : sa_reg;

    always_comb begin
        pw_en   = 1'b0;
        pw_addr = cur_reg;
        pw_data = root_sel;
        sw_en   = 1'b0;
        sw_addr = big;
        sw_data = sum_size;
        priority if (cmd.clr_step) begin
            pw_en   = 1'b1;
            pw_addr = clr_cnt_reg;
            pw_data = clr_cnt_reg;
            sw_en   = 1'b1;
            sw_addr = clr_cnt_reg;
            sw_data = SZ_W'(1);
        end else if (cmd.cmp_write) begin
            pw_en = 1'b1;
        end else if (cmd.link && unite) begin
            pw_en   = 1'b1;
            pw_addr = small_root;
            pw_data = big;
            sw_en   = 1'b1;
        end else begin
            pw_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pw_en) begin
            parent_mem[pw_addr] <= pw_data;
        end
        parent_rdata_reg <= parent_mem[cur_reg];
    end

    always_ff @(posedge aclk) begin
        if (sw_en) begin
            size_mem[sw_addr] <= sw_data;
        end
        size_rdata_reg <= size_mem[size_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= mode;
            a_reg    <= a_clamped;
            b_reg    <= b_clamped;
            cur_reg  <= a_clamped;
        end else if (cmd.cur_from_elem) begin
            cur_reg <= elem_sel;
        end else if (cmd.cur_load_b) begin
            cur_reg <= b_reg;
        end else if (cmd.cur_from_up) begin
            cur_reg <= parent_rdata_reg;
        end
        if (cmd.set_root) begin
            if (cmd.sel_b) begin
                rb_reg <= cur_reg;
            end else begin
                ra_reg <= cur_reg;
            end
        end
        if (cmd.cap_sa) begin
            sa_reg <= size_rdata_reg;
        end
        if (cmd.link) begin
            same_reg     <= (ra_reg == rb_reg);
            size_out_reg <= SIZE_OUT_W'(res_size);
            root_out_reg <= ROOT_OUT_W'(unite ? big : ra_reg);
        end
    end

    assign status.is_root  = (parent_rdata_reg == cur_reg);
    assign status.at_root  = (cur_reg == root_sel);
    assign status.clr_last = (clr_cnt_reg == LAST_IDX);

    assign same_set = same_reg;
    assign set_size = size_out_reg;
    assign set_root = root_out_reg;

    // A set that has been cleared never reports an empty size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.link |-> (sa_reg != '0) && (size_rdata_reg != '0))
        else $error("zero set size at link");

    // Merged sizes never wrap around.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.link && unite) |-> (sum_size > sa_reg) && (sum_size > size_rdata_reg))
        else $error("set size overflow on merge");

    // Compression never redirects the root itself.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cmp_write |-> (cur_reg != root_sel))
        else $error("compression write at the root");

endmodule

@@ design/uf_ctrl.sv @@
module uf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  uf_pkg::uf_status_t status,
    output uf_pkg::uf_cmd_t    cmd
);
    import uf_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_WALK_RD  = 9'b000000100,
        ST_WALK_CHK = 9'b000001000,
        ST_CMP_RD   = 9'b000010000,
        ST_CMP_CHK  = 9'b000100000,
        ST_SIZE_A   = 9'b001000000,
        ST_SIZE_B   = 9'b010000000,
        ST_LINK     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_b_reg, sel_b_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        sel_b_next   = sel_b_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.sel_b    = sel_b_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    sel_b_next = 1'b0;
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                state_next = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (status.is_root) begin
                    cmd.set_root      = 1'b1;
                    cmd.cur_from_elem = 1'b1;
                    state_next        = ST_CMP_RD;
                end else begin
                    cmd.cur_from_up = 1'b1;
                    state_next      = ST_WALK_RD;
                end
            end
            ST_CMP_RD: begin
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK: begin
                if (!status.at_root) begin
                    cmd.cmp_write   = 1'b1;
                    cmd.cur_from_up = 1'b1;
                    state_next      = ST_CMP_RD;
                end else if (!sel_b_reg) begin
                    cmd.cur_load_b = 1'b1;
                    sel_b_next     = 1'b1;
                    state_next     = ST_WALK_RD;
                end else begin
                    state_next = ST_SIZE_A;
                end
            end
            ST_SIZE_A: begin
                state_next = ST_SIZE_B;
            end
            ST_SIZE_B: begin
                cmd.size_rd_b = 1'b1;
                cmd.cap_sa    = 1'b1;
                state_next    = ST_LINK;
            end
            ST_LINK: begin
                // The second size stays on the read port until the result
                // register is free.
                cmd.size_rd_b = 1'b1;
                if (out_free) begin
                    cmd.link     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sel_b_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_b_reg   <= sel_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    // Only one word is in flight inside the engine at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while busy");

    // A result appears only from the link step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_LINK))
        else $error("result raised outside the link step");

    // The second lookup never starts before the first has finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sel_b_reg) |-> $past(state_reg == ST_CMP_CHK && status.at_root))
        else $error("second lookup started early");

endmodule

@@ design/union_find_engine.sv @@
// Channel  Direction  Fields (lowest bit first)
// s_       in         tuser: mode; tdata: first_element, second_element
// m_       out        tdata: same_set, set_size, set_root
//
// Each word is worked as a root walk and then a compression pass for each of
// its two elements in turn; then both root sizes are read and the sets are
// linked. The parent memory has a single read port. After reset the engine
// clears both memories and takes no word until that pass ends.
// A stalled result is held while the next word is accepted and worked on;
// that word then waits at its link step until the held result is taken.
module union_find_engine #(
    parameter int NUM_ELEMENTS = uf_pkg::DEF_NUM_ELEMENTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [uf_pkg::S_TDATA_W-1:0]   s_tdata,  // first_element, second_element
    input  logic [0:0]                     s_tuser,  // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [uf_pkg::M_TDATA_W-1:0]   m_tdata   // same_set, set_size, set_root
);
    import uf_pkg::*;

    uf_cmd_t               cmd;
    uf_status_t            status;
    logic                  same_set;
    logic [SIZE_OUT_W-1:0] set_size;
    logic [ROOT_OUT_W-1:0] set_root;

    uf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    uf_datapath #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .mode           (s_tuser[0]),
        .first_element  (s_tdata[ELEM_W-1:0]),
        .second_element (s_tdata[2*ELEM_W-1:ELEM_W]),
        .same_set       (same_set),
        .set_size       (set_size),
        .set_root       (set_root)
    );

    assign m_tdata = {{(M_TDATA_W - 1 - SIZE_OUT_W - ROOT_OUT_W){1'b0}},
                      set_root, set_size, same_set};

endmodule

@@ sim/union_find_engine_test.sv @@
module union_find_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import uf_pkg::*;

    localparam int NUM_ELEMS  = DEF_NUM_ELEMENTS;
    localparam int QUIET_MAX  = 5000;
    localparam int LONG_HOLD  = 300;

    typedef struct packed {
        logic                  same;
        logic [SIZE_OUT_W-1:0] size;
        logic [ROOT_OUT_W-1:0] root;
    } set_answer_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // first_element, second_element
    logic [0:0]           s_tuser = '0;   // mode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // same_set, set_size, set_root

    // Shadow copy of the disjoint-set table.
    int set_parent [NUM_ELEMS];
    int set_count  [NUM_ELEMS];

    set_answer_t pending_answers[$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    logic        idle_on = 1'b1;
    logic        long_hold_req = 1'b0;
    logic        long_hold_served = 1'b0;
    int          hold_left = 0;
    int          rx_wait = 0;

    union_find_engine #(.NUM_ELEMENTS(NUM_ELEMS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Walks to the root, then points every element on the path at it.
    function automatic int find_root(int elem);
        int r;
        int cur;
        int up;
        r = elem;
        while (set_parent[r] != r)
            r = set_parent[r];
        cur = elem;
        while (cur != r) begin
            up = set_parent[cur];
            set_parent[cur] = r;
            cur = up;
        end
        return r;
    endfunction

    function automatic set_answer_t resolve_sets(logic mode, int a, int b);
        set_answer_t ans;
        int ra;
        int rb;
        int big;
        int lesser;
        int root;
        if (a >= NUM_ELEMS) a = NUM_ELEMS - 1;
        if (b >= NUM_ELEMS) b = NUM_ELEMS - 1;
        ra = find_root(a);
        rb = find_root(b);
        root = ra;
        if (mode == MODE_UNITE && ra != rb) begin
            // On a tie the first element's root stays on top.
            if (set_count[ra] < set_count[rb]) begin
                big = rb;
                lesser = ra;
            end else begin
                big = ra;
                lesser = rb;
            end
            set_count[big] += set_count[lesser];
            set_parent[lesser] = big;
            root = big;
        end
        ans.same = (ra == rb);
        ans.size = set_count[root][SIZE_OUT_W-1:0];
        ans.root = root[ROOT_OUT_W-1:0];
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Sends one word; the caller is always at a rising edge.
    task automatic send_pair(input logic mode, input int a, input int b);
        logic [S_TDATA_W-1:0] word;
        set_answer_t answer;
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[ELEM_W-1:0] = a[ELEM_W-1:0];
        word[2*ELEM_W-1:ELEM_W] = b[ELEM_W-1:0];
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        answer = resolve_sets(mode, int'(a[ELEM_W-1:0]), int'(b[ELEM_W-1:0]));
        pending_answers = {pending_answers, answer};
    endtask

    // Result side: a random wait after each word, plus one long hold-off on request.
    always @(posedge aclk) begin
        int draw;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_served) begin
            long_hold_served <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            draw = idle_on ? $urandom_range(0, 7) : 0;
            rx_wait <= (draw > 0) ? draw - 1 : 0;
            m_tready <= (draw == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        set_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result words", 1, 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[0] !== want.same)
                    report_mismatch("same_set", int'(m_tdata[0]), int'(want.same));
                if (m_tdata[SIZE_OUT_W:1] !== want.size)
                    report_mismatch("set_size", int'(m_tdata[SIZE_OUT_W:1]),
                                    int'(want.size));
                if (m_tdata[SIZE_OUT_W+ROOT_OUT_W:SIZE_OUT_W+1] !== want.root)
                    report_mismatch("set_root",
                                    int'(m_tdata[SIZE_OUT_W+ROOT_OUT_W:SIZE_OUT_W+1]),
                                    int'(want.root));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic test_directed;
        send_pair(MODE_QUERY, 0, 0);
        send_pair(MODE_QUERY, 1023, 1023);
        send_pair(MODE_QUERY, 0, 1023);
        send_pair(MODE_UNITE, 0, 1023);      // equal sizes, first root wins
        send_pair(MODE_UNITE, 0, 1023);      // already together
        send_pair(MODE_UNITE, 1023, 5);
        send_pair(MODE_UNITE, 6, 0);         // smaller first set goes under the second
        send_pair(MODE_UNITE, 7, 8);
        send_pair(MODE_UNITE, 8, 0);
        send_pair(MODE_QUERY, 8, 1023);
        send_pair(MODE_QUERY, 8, 8);
        send_pair(MODE_UNITE, 10'h2AA, 10'h155);
        send_pair(MODE_QUERY, 10'h155, 10'h2AA);
        send_pair(MODE_UNITE, 512, 511);
        send_pair(MODE_UNITE, 511, 10'h2AA);
        send_pair(MODE_QUERY, 512, 10'h155);
        send_pair(MODE_UNITE, 1022, 1);
        send_pair(MODE_UNITE, 10'h155, 6);
        send_pair(MODE_QUERY, 1023, 512);
        send_pair(MODE_QUERY, 1, 1022);
    endtask

    // Random traffic confined to windows of varying span, so sets grow deep.
    task automatic test_random_windows;
        int i;
        int base;
        int span;
        logic mode;
        for (i = 0; i < 450; i++) begin
            if (i % 50 == 0) begin
                base = $urandom_range(0, NUM_ELEMS - 1);
                case ($urandom_range(0, 2))
                    0: span = 4;
                    1: span = 32;
                    default: span = NUM_ELEMS;
                endcase
            end
            if (i == 200) idle_on <= 1'b0;
            if (i == 300) idle_on <= 1'b1;
            mode = ($urandom_range(0, 9) < 6) ? MODE_UNITE : MODE_QUERY;
            send_pair(mode, (base + $urandom_range(0, span - 1)) % NUM_ELEMS,
                      (base + $urandom_range(0, span - 1)) % NUM_ELEMS);
        end
    endtask

    task automatic test_back_pressure;
        int i;
        idle_on <= 1'b0;
        long_hold_req <= 1'b1;
        for (i = 0; i < 12; i++)
            send_pair(1'($urandom_range(0, 1)), $urandom_range(0, NUM_ELEMS - 1),
                      $urandom_range(0, NUM_ELEMS - 1));
        idle_on <= 1'b1;
    endtask

    // Joins every element into one set, with queries scattered in between.
    task automatic test_full_merge;
        int k;
        int j;
        for (k = 1; k < NUM_ELEMS; k++) begin
            j = $urandom_range(0, k - 1);
            if ($urandom_range(0, 1))
                send_pair(MODE_UNITE, k, j);
            else
                send_pair(MODE_UNITE, j, k);
            if ($urandom_range(0, 4) == 0)
                send_pair(MODE_QUERY, $urandom_range(0, NUM_ELEMS - 1),
                          $urandom_range(0, NUM_ELEMS - 1));
        end
        for (k = 0; k < 20; k++)
            send_pair(1'($urandom_range(0, 1)), $urandom_range(0, NUM_ELEMS - 1),
                      $urandom_range(0, NUM_ELEMS - 1));
    endtask

    initial begin
        int i;
        for (i = 0; i < NUM_ELEMS; i++) begin
            set_parent[i] = i;
            set_count[i] = 1;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_windows();
        test_back_pressure();
        test_full_merge();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/uf_pkg.sv
design/uf_datapath.sv
design/uf_ctrl.sv
design/union_find_engine.sv
sim/union_find_engine_test.sv
